@@ rtl/incircle_test_circumcenter_assert.svh @@
// Assertion macros used by the checker file.
`ifndef INCIRCLE_TEST_CIRCUMCENTER_ASSERT_SVH
`define INCIRCLE_TEST_CIRCUMCENTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ICC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/icc_pkg.sv @@
package icc_pkg;

  // Default coordinate width (signed fixed point).
  localparam int unsigned COORD_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_A_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_Y  = 3'd5;

  // Setup sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_END
  } setup_state_e;

  // Multiply-accumulate steps of the triangle setup.
  typedef enum logic [3:0] {
    STEP_U1SQ,
    STEP_W1,
    STEP_U2SQ,
    STEP_W2,
    STEP_K1A,
    STEP_K1,
    STEP_K2A,
    STEP_K2,
    STEP_K3A,
    STEP_K3,
    STEP_NX,
    STEP_NY
  } mac_step_e;

  // Status of the triangle setup, seen by the datapath.
  typedef struct packed {
    logic busy;
    logic degenerate;
    logic clipped;
  } icc_status_t;

endpackage

@@ rtl/icc_fifo.sv @@
module icc_fifo #(
  parameter int unsigned W = 34
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  import icc_pkg::*;

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/icc_front.sv @@
module icc_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic                         hold_i,
  input  logic                         fifo_full_i,
  output logic                         push_o,
  output logic [2*COORD_BITS+1:0]      push_data_o
);
  import icc_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  logic                 f_valid_q, f_valid_d;
  logic signed [DW-1:0] u3_q, v3_q;
  logic                 accept;

  // The holding register drains into the queue whenever it has room.
  assign push_o      = f_valid_q && !fifo_full_i;
  assign in_stall_o  = hold_i || (f_valid_q && fifo_full_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = {u3_q, v3_q};

  always_comb begin
    f_valid_d = accept || (f_valid_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  // The point is moved to vertex A as origin on entry.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      u3_q <= DW'(point_x_i) - DW'(a_x_i);
      v3_q <= DW'(point_y_i) - DW'(a_y_i);
    end
  end

endmodule

@@ rtl/icc_setup.sv @@
module icc_setup #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [icc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [COORD_BITS-1:0]                cfg_data_i,
  output logic signed [COORD_BITS-1:0]         a_x_o,
  output logic signed [COORD_BITS-1:0]         a_y_o,
  output logic signed [3*COORD_BITS+4:0]       k1_o,
  output logic signed [3*COORD_BITS+4:0]       k2_o,
  output logic signed [2*COORD_BITS+2:0]       k3_o,
  output logic signed [COORD_BITS-1:0]         center_x_o,
  output logic signed [COORD_BITS-1:0]         center_y_o,
  output icc_pkg::icc_status_t                 status_o
);
  import icc_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned WW = 2 * DW + 1;
  localparam int unsigned KW = 3 * DW + 2;
  localparam int unsigned NW = 3 * DW + 4;
  localparam int unsigned PW = DW + WW;
  localparam int unsigned CW = $clog2(NW);
  localparam logic [NW:0] LIM_NEG = (NW+1)'(64'd1 << (COORD_BITS - 1));
  localparam logic [NW:0] LIM_POS = LIM_NEG - (NW+1)'(1);

  setup_state_e state_q, state_d;
  mac_step_e    step_q, step_d;

  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [COORD_BITS-1:0] ax_d, ay_d, bx_d, by_d, cx_d, cy_d;
  logic signed [WW-1:0] w1_q, w1_d, w2_q, w2_d;
  logic signed [NW-1:0] acc_q, acc_d, nx_q, nx_d, ny_q, ny_d;
  logic signed [KW-1:0] k1_q, k1_d, k2_q, k2_d;
  logic signed [WW-1:0] k3_q, k3_d;
  logic signed [COORD_BITS-1:0] cen_x_q, cen_x_d, cen_y_q, cen_y_d;
  logic deg_q, deg_d, clip_q, clip_d, sel_y_q, sel_y_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] n_q, n_d, q_q, q_d;
  logic [KW-1:0] r_q, r_d;
  logic          neg_q, neg_d;

  logic signed [DW-1:0] u1, v1, u2, v2, ma;
  logic signed [WW-1:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] prod_x, num;
  logic [WW-1:0]        k3_abs;
  logic [KW-1:0]        ad, rs;
  logic                 ge, rnd, over;
  logic [NW:0]          qr, qs, lim;
  logic [NW-1:0]        num_abs;
  logic [COORD_BITS-1:0] cval;

  assign cfg_ready_o = 1'b1;
  assign a_x_o       = ax_q;
  assign a_y_o       = ay_q;
  assign k1_o        = k1_q;
  assign k2_o        = k2_q;
  assign k3_o        = k3_q;
  assign center_x_o  = cen_x_q;
  assign center_y_o  = cen_y_q;
  assign status_o    = '{busy: (state_q != ST_IDLE), degenerate: deg_q, clipped: clip_q};

  // Edge vectors relative to vertex A.
  assign u1 = DW'(bx_q) - DW'(ax_q);
  assign v1 = DW'(by_q) - DW'(ay_q);
  assign u2 = DW'(cx_q) - DW'(ax_q);
  assign v2 = DW'(cy_q) - DW'(ay_q);

  // Shared multiplier operand selection.
  always_comb begin
    unique case (step_q)
      STEP_U1SQ: begin ma = u1; mb = WW'(u1); end
      STEP_W1:   begin ma = v1; mb = WW'(v1); end
      STEP_U2SQ: begin ma = u2; mb = WW'(u2); end
      STEP_W2:   begin ma = v2; mb = WW'(v2); end
      STEP_K1A:  begin ma = v1; mb = w2_q; end
      STEP_K1:   begin ma = v2; mb = w1_q; end
      STEP_K2A:  begin ma = u1; mb = w2_q; end
      STEP_K2:   begin ma = u2; mb = w1_q; end
      STEP_K3A:  begin ma = u1; mb = WW'(v2); end
      STEP_K3:   begin ma = v1; mb = WW'(u2); end
      STEP_NX:   begin ma = DW'(ax_q); mb = k3_q; end
      STEP_NY:   begin ma = DW'(ay_q); mb = k3_q; end
      default:   begin ma = u1; mb = WW'(u1); end
    endcase
  end

  assign prod   = ma * mb;
  assign prod_x = NW'(prod);

  // Divider operands: the divisor is |2 * K3|.
  assign k3_abs  = k3_q[WW-1] ? WW'(-k3_q) : WW'(k3_q);
  assign ad      = KW'({k3_abs, 1'b0});
  assign num     = sel_y_q ? ny_q : nx_q;
  assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
  assign rs      = {r_q[KW-2:0], n_q[NW-1]};
  assign ge      = (rs >= ad);

  // Round half away from zero, then saturate.
  assign rnd  = ({r_q, 1'b0} >= {1'b0, ad});
  assign qr   = {1'b0, q_q} + (NW+1)'(rnd);
  assign lim  = neg_q ? LIM_NEG : LIM_POS;
  assign over = (qr > lim);
  assign qs   = over ? lim : qr;
  assign cval = neg_q ? COORD_BITS'(-qs) : COORD_BITS'(qs);

  // Next state and datapath of the setup sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q; cx_d = cx_q; cy_d = cy_q;
    w1_d = w1_q; w2_d = w2_q; acc_d = acc_q; nx_d = nx_q; ny_d = ny_q;
    k1_d = k1_q; k2_d = k2_q; k3_d = k3_q;
    cen_x_d = cen_x_q; cen_y_d = cen_y_q;
    deg_d = deg_q; clip_d = clip_q; sel_y_d = sel_y_q;
    cnt_d = cnt_q; n_d = n_q; q_d = q_q; r_d = r_q; neg_d = neg_q;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_MAC: begin
        unique case (step_q)
          STEP_U1SQ, STEP_U2SQ, STEP_K1A, STEP_K2A, STEP_K3A: acc_d = prod_x;
          STEP_W1: w1_d = WW'(acc_q + prod_x);
          STEP_W2: w2_d = WW'(acc_q + prod_x);
          STEP_K1: k1_d = KW'(acc_q - prod_x);
          STEP_K2: k2_d = KW'(prod_x - acc_q);
          STEP_K3: k3_d = WW'(acc_q - prod_x);
          STEP_NX: nx_d = (prod_x <<< 1) - NW'(k1_q);
          STEP_NY: ny_d = (prod_x <<< 1) - NW'(k2_q);
          default: ;
        endcase
        if (step_q == STEP_NY) begin
          clip_d  = 1'b0;
          sel_y_d = 1'b0;
          if (k3_q == '0) begin
            deg_d   = 1'b1;
            cen_x_d = '0;
            cen_y_d = '0;
            state_d = ST_IDLE;
          end else begin
            deg_d   = 1'b0;
            state_d = ST_DIV_LOAD;
          end
        end else begin
          step_d = mac_step_e'(step_q + 4'd1);
        end
      end
      ST_DIV_LOAD: begin
        neg_d   = num[NW-1] ^ k3_q[WW-1];
        n_d     = num_abs;
        r_d     = '0;
        q_d     = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        r_d   = ge ? rs - ad : rs;
        q_d   = {q_q[NW-2:0], ge};
        n_d   = n_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          state_d = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        clip_d = clip_q | over;
        if (sel_y_q) begin
          cen_y_d = cval;
          state_d = ST_IDLE;
        end else begin
          cen_x_d = cval;
          sel_y_d = 1'b1;
          state_d = ST_DIV_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A write to a vertex register restarts the setup from the first step.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_A_X: ax_d = cfg_data_i;
        REG_A_Y: ay_d = cfg_data_i;
        REG_B_X: bx_d = cfg_data_i;
        REG_B_Y: by_d = cfg_data_i;
        REG_C_X: cx_d = cfg_data_i;
        REG_C_Y: cy_d = cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i <= REG_C_Y) begin
        state_d = ST_MAC;
        step_d  = STEP_U1SQ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_U1SQ;
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0; cx_q <= '0; cy_q <= '0;
      k1_q <= '0; k2_q <= '0; k3_q <= '0;
      cen_x_q <= '0;
      cen_y_q <= '0;
      deg_q   <= 1'b1;
      clip_q  <= 1'b0;
      sel_y_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d; cx_q <= cx_d; cy_q <= cy_d;
      k1_q <= k1_d; k2_q <= k2_d; k3_q <= k3_d;
      cen_x_q <= cen_x_d;
      cen_y_q <= cen_y_d;
      deg_q   <= deg_d;
      clip_q  <= clip_d;
      sel_y_q <= sel_y_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers of the multiply and divide steps.
  always_ff @(posedge clk_i) begin
    w1_q  <= w1_d;
    w2_q  <= w2_d;
    acc_q <= acc_d;
    nx_q  <= nx_d;
    ny_q  <= ny_d;
    n_q   <= n_d;
    q_q   <= q_d;
    r_q   <= r_d;
    neg_q <= neg_d;
  end

endmodule

@@ rtl/icc_back.sv @@
module icc_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  output logic                           pop_o,
  input  logic [2*COORD_BITS+1:0]        pop_data_i,
  input  logic signed [3*COORD_BITS+4:0] k1_i,
  input  logic signed [3*COORD_BITS+4:0] k2_i,
  input  logic signed [2*COORD_BITS+2:0] k3_i,
  input  logic signed [COORD_BITS-1:0]   center_x_i,
  input  logic signed [COORD_BITS-1:0]   center_y_i,
  input  icc_pkg::icc_status_t           status_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           inside_res_o,
  output logic signed [COORD_BITS-1:0]   center_x_o,
  output logic signed [COORD_BITS-1:0]   center_y_o,
  output logic                           degenerate_o,
  output logic                           center_clipped_o
);
  import icc_pkg::*;

  localparam int unsigned DW   = COORD_BITS + 1;
  localparam int unsigned WW   = 2 * DW + 1;
  localparam int unsigned KW   = 3 * DW + 2;
  localparam int unsigned H    = (KW + 1) / 2;
  localparam int unsigned HI   = KW - H;
  localparam int unsigned DETW = 4 * DW + 4;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [DW-1:0] u3_in, v3_in, s1_u_q, s1_v_q, s2_u_n, s2_v_n;
  logic signed [WW-1:0] s1_w_q;
  logic signed [KW-1:0] k3_e;
  logic signed [HI-1:0] k1_hi, k2_hi, k3_hi;
  logic signed [H:0]    k1_lo, k2_lo, k3_lo;
  logic signed [DW+HI-1:0] p1h_q, p2h_q;
  logic signed [DW+H:0]    p1l_q, p2l_q;
  logic signed [WW+HI-1:0] p3h_q;
  logic signed [WW+H:0]    p3l_q;
  logic signed [DETW-1:0]  t1_q, t2_q, t3_q, det;
  logic signed [2*DW-1:0]  sq_u, sq_v;

  // Stall chain: a stage moves when it is empty or its successor moves.
  assign rdy4  = !v4_q || !out_stall_i;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign pop_o = !empty_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pop_o;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: squared distance of the point from vertex A.
  assign u3_in = $signed(pop_data_i[2*DW-1:DW]);
  assign v3_in = $signed(pop_data_i[DW-1:0]);
  assign sq_u  = u3_in * u3_in;
  assign sq_v  = v3_in * v3_in;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_u_q <= u3_in;
      s1_v_q <= v3_in;
      s1_w_q <= WW'(sq_u) + WW'(sq_v);
    end
  end

  // Stage 2: partial products against the split triangle cofactors.
  assign k3_e  = KW'(k3_i);
  assign k1_hi = $signed(k1_i[KW-1:H]);
  assign k2_hi = $signed(k2_i[KW-1:H]);
  assign k3_hi = $signed(k3_e[KW-1:H]);
  assign k1_lo = $signed({1'b0, k1_i[H-1:0]});
  assign k2_lo = $signed({1'b0, k2_i[H-1:0]});
  assign k3_lo = $signed({1'b0, k3_e[H-1:0]});
  assign s2_u_n = s1_u_q;
  assign s2_v_n = s1_v_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p1h_q <= s2_u_n * k1_hi;
      p1l_q <= s2_u_n * k1_lo;
      p2h_q <= s2_v_n * k2_hi;
      p2l_q <= s2_v_n * k2_lo;
      p3h_q <= s1_w_q * k3_hi;
      p3l_q <= s1_w_q * k3_lo;
    end
  end

  // Stage 3: reassemble the three cofactor terms.
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      t1_q <= (DETW'(p1h_q) <<< H) + DETW'(p1l_q);
      t2_q <= (DETW'(p2h_q) <<< H) + DETW'(p2l_q);
      t3_q <= (DETW'(p3h_q) <<< H) + DETW'(p3l_q);
    end
  end

  // Stage 4: determinant sign and the output register.
  assign det = t1_q + t2_q + t3_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      inside_res_o     <= det[DETW-1];
      center_x_o       <= center_x_i;
      center_y_o       <= center_y_i;
      degenerate_o     <= status_i.degenerate;
      center_clipped_o <= status_i.clipped;
    end
  end

  assign out_valid_o = v4_q;

endmodule

@@ rtl/incircle_test_circumcenter.sv @@
// Channel   Handshake             Payload
// ------    --------------------  ---------------------------------------------
// in        in_valid_i/in_stall_o point_x_i, point_y_i
// out       out_valid_o/out_stall_i inside_res_o, center_x_o, center_y_o,
//                                 degenerate_o, center_clipped_o
// cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One point is taken per cycle while in_stall_o is low; a result passes
// through the front register, the two-entry queue and four datapath stages.
// A write to a vertex register starts the triangle setup on one shared
// multiplier and a bit-serial divider; in_stall_o is high while it runs.
// Reset leaves all vertices at zero.
// A stalled output holds its item; the queue keeps the input side moving.
module incircle_test_circumcenter #(
  parameter int unsigned COORD_BITS = icc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o,
  output logic signed [COORD_BITS-1:0]  center_x_o,
  output logic signed [COORD_BITS-1:0]  center_y_o,
  output logic                          degenerate_o,
  output logic                          center_clipped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [icc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]         cfg_data_i
);
  import icc_pkg::*;

  localparam int unsigned QW = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0]   a_x, a_y, cen_x, cen_y;
  logic signed [3*COORD_BITS+4:0] k1, k2;
  logic signed [2*COORD_BITS+2:0] k3;
  icc_status_t                    status;
  logic                           push, pop, full, empty;
  logic [QW-1:0]                  push_data, pop_data;

  // Triangle setup from the configuration registers.
  icc_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .a_x_o(a_x), .a_y_o(a_y), .k1_o(k1), .k2_o(k2), .k3_o(k3),
    .center_x_o(cen_x), .center_y_o(cen_y), .status_o(status)
  );

  // Point intake.
  icc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .point_x_i, .point_y_i,
    .a_x_i(a_x), .a_y_i(a_y), .hold_i(status.busy || cfg_valid_i),
    .fifo_full_i(full), .push_o(push), .push_data_o(push_data)
  );

  // Queue between intake and datapath.
  icc_fifo #(.W(QW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(full),
    .pop_i(pop), .data_o(pop_data), .empty_o(empty)
  );

  // Determinant datapath and output register.
  icc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .pop_o(pop), .pop_data_i(pop_data),
    .k1_i(k1), .k2_i(k2), .k3_i(k3), .center_x_i(cen_x), .center_y_i(cen_y),
    .status_i(status), .out_valid_o, .out_stall_i, .inside_res_o,
    .center_x_o, .center_y_o, .degenerate_o, .center_clipped_o
  );

endmodule

@@ rtl/icc_checker.sv @@
`include "incircle_test_circumcenter_assert.svh"

module icc_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         cfg_valid_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         inside_res_o,
  input logic signed [COORD_BITS-1:0] center_x_o,
  input logic signed [COORD_BITS-1:0] center_y_o,
  input logic                         degenerate_o,
  input logic                         center_clipped_o
);
  import icc_pkg::*;

  localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // A stalled result stays put.
  `ICC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(inside_res_o) && $stable(center_x_o) && $stable(center_y_o),
    "stalled result changed")

  // Collinear vertices report a zero, unclipped center.
  `ICC_ASSERT(a_degen_zero, out_valid_o && degenerate_o,
    center_x_o == '0 && center_y_o == '0 && !center_clipped_o,
    "degenerate result with nonzero center")

  // A clipped center sits on a range limit.
  `ICC_ASSERT(a_clip_limit, out_valid_o && center_clipped_o,
    center_x_o == CMAX || center_x_o == CMIN || center_y_o == CMAX || center_y_o == CMIN,
    "clipped center not at a limit")

  // Points are held off while a register write is in flight.
  `ICC_ASSERT(a_cfg_blocks, cfg_valid_i, in_stall_o, "point accepted during config write")

endmodule

bind incircle_test_circumcenter icc_checker #(.COORD_BITS(COORD_BITS)) u_icc_checker (.*);

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import icc_pkg::*;

  localparam int unsigned CW        = 16;
  localparam int unsigned MAX_CYCLE = 400000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic   in_circle;
    coord_t cx;
    coord_t cy;
    logic   degen;
    logic   clip;
  } circle_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  coord_t               point_x_i = '0;
  coord_t               point_y_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 inside_res_o;
  coord_t               center_x_o;
  coord_t               center_y_o;
  logic                 degenerate_o;
  logic                 center_clipped_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CW-1:0]        cfg_data_i = '0;

  // Shadow copy of the vertex registers.
  coord_t      vtx [6];
  circle_res_t circle_q [$];
  int          n_err = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  incircle_test_circumcenter #(.COORD_BITS(CW)) u_top (.*);

  always #5 clk_i = ~clk_i;

  // Rounded, saturated quotient for one center coordinate.
  function automatic coord_t center_div(input wide_t n, input wide_t d, inout logic clip);
    logic  neg;
    wide_t an, ad, q, r, lim;
    neg = (n < 0) != (d < 0);
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    q   = an / ad;
    r   = an % ad;
    if (2 * r >= ad) q = q + 1;
    lim = neg ? 128'sd32768 : 128'sd32767;
    if (q > lim) begin
      q    = lim;
      clip = 1'b1;
    end
    if (neg) q = -q;
    return q[CW-1:0];
  endfunction

  // Exact incircle determinant and circumcenter for one point.
  function automatic circle_res_t incircle_predict(input coord_t px, input coord_t py);
    wide_t ax, ay, bx, by, cx, cy, u1, v1, u2, v2, u3, v3, w1, w2, w3;
    wide_t det, sa, sb, sc, dd, nx, ny;
    circle_res_t res;
    ax = vtx[0]; ay = vtx[1]; bx = vtx[2]; by = vtx[3]; cx = vtx[4]; cy = vtx[5];
    u1 = bx - ax; v1 = by - ay;
    u2 = cx - ax; v2 = cy - ay;
    u3 = wide_t'(px) - ax; v3 = wide_t'(py) - ay;
    w1 = u1 * u1 + v1 * v1;
    w2 = u2 * u2 + v2 * v2;
    w3 = u3 * u3 + v3 * v3;
    det = u1 * (v2 * w3 - w2 * v3) - v1 * (u2 * w3 - w2 * u3) + w1 * (u2 * v3 - v2 * u3);
    sa = ax * ax + ay * ay;
    sb = bx * bx + by * by;
    sc = cx * cx + cy * cy;
    dd = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
    nx = sa * (by - cy) + sb * (cy - ay) + sc * (ay - by);
    ny = sa * (cx - bx) + sb * (ax - cx) + sc * (bx - ax);
    res           = '0;
    res.in_circle = det < 0;
    res.degen     = dd == 0;
    if (dd != 0) begin
      res.cx = center_div(nx, dd, res.clip);
      res.cy = center_div(ny, dd, res.clip);
    end
    return res;
  endfunction

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("incircle_test_circumcenter regression: fail");
      $finish;
    end
  end

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    circle_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{inside_res_o, center_x_o, center_y_o, degenerate_o, center_clipped_o};
      if (circle_q.size() == 0) begin
        n_err = n_err + 1;
        if (n_err <= 10) $display("unexpected result item %p", got);
      end else begin
        want = circle_q.pop_front();
        if (got !== want) begin
          n_err = n_err + 1;
          if (n_err <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Send one point and record its predicted result.
  task automatic send_point(input coord_t px, input coord_t py);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= px;
    point_y_i  <= py;
    do @(posedge clk_i); while (in_stall_o);
    circle_q.push_back(incircle_predict(px, py));
  endtask

  // Wait until every prediction is matched, then let the pipe settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (circle_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write one register and wait out the triangle setup.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < 6) vtx[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
  endtask

  task automatic set_triangle(input coord_t ax, ay, bx, by, cx, cy);
    drain();
    write_reg(REG_A_X, ax);
    write_reg(REG_A_Y, ay);
    write_reg(REG_B_X, bx);
    write_reg(REG_B_Y, by);
    write_reg(REG_C_X, cx);
    write_reg(REG_C_Y, cy);
  endtask

  // Reset state: all vertices at zero, so every result is degenerate.
  task automatic test_reset_triangle();
    send_point(16'sh0000, 16'sh0000);
    send_point(16'sh7fff, 16'sh8000);
  endtask

  // Right triangle with legs of 256: inside, outside, on the circle, field extremes.
  task automatic test_directed_points();
    set_triangle(0, 0, 256, 0, 0, 256);
    send_point(64, 64);
    send_point(256, 256);
    send_point(1000, 1000);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff);
    send_point(-1, -1);
    // Reversed orientation flips the predicate.
    set_triangle(0, 0, 0, 256, 256, 0);
    send_point(64, 64);
    send_point(1000, 1000);
  endtask

  // Collinear vertices, a far-away center that saturates, and unused register indexes.
  task automatic test_special_cases();
    set_triangle(0, 0, 100, 100, -200, -200);
    send_point(5, 7);
    send_point(16'sh7fff, 16'sh8000);
    set_triangle(16'sh8000, 0, 16'sh7fff, 1, 0, 0);
    send_point(0, 1);
    send_point(-5, 3);
    set_triangle(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_point(0, 0);
    send_point(16'sh7fff, 16'sh7fff);
    // Writes to unused indexes must leave the triangle unchanged.
    drain();
    write_reg(3'd6, 16'sh1234);
    write_reg(3'd7, 16'sh7fff);
    send_point(1, 2);
  endtask

  // Random triangles, some collinear, with points near them, plus raw noise points.
  task automatic test_random_phase(input int idle, input int stall, input int n_items);
    coord_t t [6];
    int     span;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) begin
        span = ($urandom_range(3) == 0) ? 65535 : $urandom_range(4095, 16);
        foreach (t[k]) t[k] = (span == 65535) ? coord_t'($urandom)
                                              : coord_t'($urandom_range(span) - span / 2);
        if ($urandom_range(9) == 0) begin
          t[4] = t[0] + 2 * (t[2] - t[0]);
          t[5] = t[1] + 2 * (t[3] - t[1]);
        end
        set_triangle(t[0], t[1], t[2], t[3], t[4], t[5]);
      end
      if ($urandom_range(4) == 0) send_point(coord_t'($urandom), coord_t'($urandom));
      else send_point(vtx[$urandom_range(2) * 2] + coord_t'($urandom_range(span) - span / 2),
                      vtx[$urandom_range(2) * 2 + 1] + coord_t'($urandom_range(span) - span / 2));
    end
  endtask

  initial begin
    foreach (vtx[k]) vtx[k] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_triangle();
    test_directed_points();
    test_special_cases();
    test_random_phase(0, 0, 100);
    test_random_phase(69, 0, 100);
    test_random_phase(0, 69, 100);
    test_random_phase(28, 28, 100);
    stall_pct = 0;
    drain();
    if (n_err == 0 && circle_q.size() == 0) begin
      $display("incircle_test_circumcenter regression: pass");
    end else begin
      $display("incircle_test_circumcenter regression: fail");
    end
    $finish;
  end

endmodule
